FILE: rtl/core/dhcp_option_field_parser_unit_macros.svh
// Assertion macros used by the DHCP option parser top level.
`ifndef DHCP_OPTION_FIELD_PARSER_UNIT_MACROS_SVH
`define DHCP_OPTION_FIELD_PARSER_UNIT_MACROS_SVH

// Check a property on every rising clock edge, skipped while reset is low.
`define DOFP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("dhcp option parser check failed");

// Check that a condition implies a consequence in the cycle after it.
`define DOFP_ASSERT_NEXT(lbl, cond, conseq) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (conseq)) \
    else $error("dhcp option parser check failed");

`endif

FILE: rtl/core/dhcp_ofp_pkg.sv
// Types, option codes and helpers for the DHCP option parser.
`timescale 1ns / 1ps
package dhcp_ofp_pkg;

  localparam logic [7:0] CODE_PAD    = 8'd0;
  localparam logic [7:0] CODE_MASK   = 8'd1;
  localparam logic [7:0] CODE_ROUTER = 8'd3;
  localparam logic [7:0] CODE_DNS    = 8'd6;
  localparam logic [7:0] CODE_TYPE   = 8'd53;
  localparam logic [7:0] CODE_END    = 8'd255;

  // found flag bits
  localparam int unsigned FLG_TYPE   = 0;
  localparam int unsigned FLG_MASK   = 1;
  localparam int unsigned FLG_ROUTER = 2;
  localparam int unsigned FLG_DNS    = 3;

  typedef enum logic [1:0] {
    PH_CODE  = 2'd0,
    PH_LEN   = 2'd1,
    PH_VALUE = 2'd2,
    PH_DONE  = 2'd3
  } phase_e;

  typedef struct packed {
    phase_e      phase;
    logic [7:0]  code;
    logic [7:0]  bytes_left;
    logic [1:0]  pos;
    logic [7:0]  type_value;
    logic [31:0] mask_word;
    logic [31:0] router_word;
    logic [31:0] dns_word;
    logic [3:0]  found;
    logic        finished;
  } walk_state_t;

  // One-hot found flag for the codes that are captured, zero otherwise.
  function automatic logic [3:0] flag_of(input logic [7:0] code);
    logic [3:0] f;
    f = 4'b0000;
    if (code == CODE_TYPE)   f[FLG_TYPE]   = 1'b1;
    if (code == CODE_MASK)   f[FLG_MASK]   = 1'b1;
    if (code == CODE_ROUTER) f[FLG_ROUTER] = 1'b1;
    if (code == CODE_DNS)    f[FLG_DNS]    = 1'b1;
    return f;
  endfunction

endpackage

FILE: rtl/core/dhcp_ofp_walker.sv
// Next-state logic of the option walker for one incoming byte.
`timescale 1ns / 1ps
module dhcp_ofp_walker
  import dhcp_ofp_pkg::*;
(
  input  walk_state_t cur_i,
  input  logic [7:0]  byte_i,
  output walk_state_t nxt_o
);

  logic [3:0]  flag;
  logic [31:0] lane;
  logic [7:0]  left_dec;

  assign flag     = flag_of(cur_i.code);
  // place the byte in its lane, first value byte most significant
  assign lane     = {byte_i, 24'h000000} >> {cur_i.pos, 3'b000};
  assign left_dec = cur_i.bytes_left - 8'd1;

  always_comb begin
    nxt_o = cur_i;
    unique case (cur_i.phase)
      PH_CODE: begin
        if (byte_i == CODE_END) begin
          nxt_o.finished = 1'b1;
          nxt_o.phase    = PH_DONE;
        end else if (byte_i != CODE_PAD) begin
          nxt_o.code  = byte_i;
          nxt_o.phase = PH_LEN;
        end
      end
      PH_LEN: begin
        // drop codes of no interest and codes already captured
        if (flag == 4'b0000 || (cur_i.found & flag) != 4'b0000) begin
          nxt_o.code = CODE_PAD;
        end
        nxt_o.bytes_left = byte_i;
        nxt_o.pos        = 2'd0;
        nxt_o.phase      = (byte_i == 8'd0) ? PH_CODE : PH_VALUE;
      end
      PH_VALUE: begin
        if (flag != 4'b0000) begin
          nxt_o.found = cur_i.found | flag;
          if (flag[FLG_TYPE]) begin
            nxt_o.type_value = byte_i;
            nxt_o.code       = CODE_PAD;
          end else begin
            if (flag[FLG_MASK])   nxt_o.mask_word   = cur_i.mask_word | lane;
            if (flag[FLG_ROUTER]) nxt_o.router_word = cur_i.router_word | lane;
            if (flag[FLG_DNS])    nxt_o.dns_word    = cur_i.dns_word | lane;
            if (cur_i.pos == 2'd3) nxt_o.code = CODE_PAD;
            else                   nxt_o.pos  = cur_i.pos + 2'd1;
          end
        end
        nxt_o.bytes_left = left_dec;
        if (left_dec == 8'd0) nxt_o.phase = PH_CODE;
      end
      PH_DONE: begin
        // ignore everything after the end option
      end
      default: begin
        nxt_o = cur_i;
      end
    endcase
  end

endmodule

FILE: rtl/core/dhcp_option_field_parser_unit.sv
// Top level of the DHCP option parser: walk state, result register, handshakes.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+-------------------------------------
//   in      | sink      | in_valid_i/in_ready_o | option_byte_i, last_byte_i
//   out     | source    | out_valid_o/out_ready_i | message_type_o .. truncated_o
//
// One byte per cycle while in_ready_o is high; each byte updates the walk state in the cycle it is taken.
// The result of a message is registered on the edge that takes its last byte and
// shows in the cycle after. The walk state returns to its reset value on that edge.
// Reset clears the walk state and the result valid flag.
// Bytes keep flowing while a result waits; only a last byte stalls, until the
// waiting result is taken (or is taken in the same cycle).
`timescale 1ns / 1ps
`include "dhcp_option_field_parser_unit_macros.svh"
module dhcp_option_field_parser_unit
  import dhcp_ofp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  option_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  message_type_o,
  output logic        type_found_o,
  output logic [31:0] subnet_mask_o,
  output logic        mask_found_o,
  output logic [31:0] router_address_o,
  output logic        router_found_o,
  output logic [31:0] dns_address_o,
  output logic        dns_found_o,
  output logic        end_seen_o,
  output logic        truncated_o
);

  walk_state_t state_q, state_d;
  logic        in_xfer;
  logic        done_xfer;
  logic        out_valid_q, out_valid_d;
  logic        walk_done;

  logic [7:0]  type_q;
  logic [31:0] mask_q, router_q, dns_q;
  logic [3:0]  found_q;
  logic        end_q, trunc_q;

  dhcp_ofp_walker u_walker (
    .cur_i  (state_q),
    .byte_i (option_byte_i),
    .nxt_o  (state_d)
  );

  assign in_ready_o = !out_valid_q || out_ready_i || !last_byte_i;
  assign in_xfer    = in_valid_i && in_ready_o;
  assign done_xfer  = in_xfer && last_byte_i;
  assign walk_done  = (state_q.phase == PH_DONE);

  always_comb begin
    out_valid_d = out_valid_q;
    if (done_xfer)        out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (in_xfer) begin
        // clear the walk once the message is complete
        state_q <= last_byte_i ? '0 : state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (done_xfer) begin
      type_q   <= state_d.found[FLG_TYPE] ? state_d.type_value : 8'd0;
      mask_q   <= state_d.mask_word;
      router_q <= state_d.router_word;
      dns_q    <= state_d.dns_word;
      found_q  <= state_d.found;
      end_q    <= state_d.finished;
      trunc_q  <= !state_d.finished && (state_d.phase != PH_CODE);
    end
  end

  assign out_valid_o      = out_valid_q;
  assign message_type_o   = type_q;
  assign type_found_o     = found_q[FLG_TYPE];
  assign subnet_mask_o    = mask_q;
  assign mask_found_o     = found_q[FLG_MASK];
  assign router_address_o = router_q;
  assign router_found_o   = found_q[FLG_ROUTER];
  assign dns_address_o    = dns_q;
  assign dns_found_o      = found_q[FLG_DNS];
  assign end_seen_o       = end_q;
  assign truncated_o      = trunc_q;

  `DOFP_ASSERT_NEXT(a_last_gives_result, done_xfer, out_valid_q)
  `DOFP_ASSERT_NEXT(a_last_clears_walk, done_xfer, state_q == '0)
  `DOFP_ASSERT(a_mask_zero_until_found, !state_q.found[FLG_MASK] |-> state_q.mask_word == 32'd0)
  `DOFP_ASSERT_NEXT(a_done_sticks, walk_done && !done_xfer, walk_done && state_q.finished)
  `DOFP_ASSERT(a_done_means_end, state_q.finished == walk_done)

endmodule

FILE: dv/tb_dhcp_option_field_parser_unit.sv
// Self-checking testbench for the DHCP option parser: directed table, then random messages.
`timescale 1ns / 1ps
module tb_dhcp_option_field_parser_unit
  import dhcp_ofp_pkg::*;
();

  localparam int unsigned RANDOM_BYTES   = 1800;
  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned DRAIN_CYCLES   = 10;
  // code value that marks an entry whose value bytes are skipped
  localparam logic [7:0]  NO_CAPTURE     = 8'h00;

  typedef struct packed {
    logic [7:0]  message_type;
    logic        type_found;
    logic [31:0] subnet_mask;
    logic        mask_found;
    logic [31:0] router_address;
    logic        router_found;
    logic [31:0] dns_address;
    logic        dns_found;
    logic        end_seen;
    logic        truncated;
  } result_t;

  localparam result_t NO_RESULT = '0;

  typedef struct packed {
    logic [7:0] b;
    logic       last;
    logic       typed;
    result_t    exp;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  option_byte_i = 8'h00;
  logic        last_byte_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [7:0]  message_type_o;
  logic        type_found_o;
  logic [31:0] subnet_mask_o;
  logic        mask_found_o;
  logic [31:0] router_address_o;
  logic        router_found_o;
  logic [31:0] dns_address_o;
  logic        dns_found_o;
  logic        end_seen_o;
  logic        truncated_o;

  walk_state_t walk;
  result_t     pending_results [$];
  result_t     seen_res;
  result_t     want_res;
  logic [7:0]  msg_bytes [$];
  row_t        dir_rows [26];
  int unsigned mismatches = 0;
  int unsigned bytes_taken = 0;
  int unsigned quiet_cycles = 0;
  bit          calm = 1'b0;

  dhcp_option_field_parser_unit DUT (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [3:0] option_flag(input logic [7:0] c);
    logic [3:0] f;
    f = 4'b0000;
    case (c)
      CODE_TYPE:   f[FLG_TYPE]   = 1'b1;
      CODE_MASK:   f[FLG_MASK]   = 1'b1;
      CODE_ROUTER: f[FLG_ROUTER] = 1'b1;
      CODE_DNS:    f[FLG_DNS]    = 1'b1;
      default:     f = 4'b0000;
    endcase
    return f;
  endfunction

  // Advance the option walk by one byte; returns 1 with the message summary on a last byte.
  function automatic bit walk_byte(input logic [7:0] b, input logic last, output result_t res);
    logic [3:0]  f;
    int unsigned shift;
    res = '0;
    case (walk.phase)
      PH_CODE: begin
        if (b == CODE_END) begin
          walk.finished = 1'b1;
          walk.phase = PH_DONE;
        end else if (b != CODE_PAD) begin
          walk.code = b;
          walk.phase = PH_LEN;
        end
      end
      PH_LEN: begin
        f = option_flag(walk.code);
        // skip codes of no interest and repeats of codes already captured
        if (f == 4'b0000 || (walk.found & f) != 4'b0000) walk.code = NO_CAPTURE;
        walk.bytes_left = b;
        walk.pos = 2'd0;
        if (b == 8'h00) walk.phase = PH_CODE;
        else walk.phase = PH_VALUE;
      end
      PH_VALUE: begin
        f = option_flag(walk.code);
        if (f != 4'b0000) begin
          walk.found = walk.found | f;
          if (walk.code == CODE_TYPE) begin
            walk.type_value = b;
            walk.code = NO_CAPTURE;
          end else begin
            shift = 24 - 8 * walk.pos;
            if (walk.code == CODE_MASK) walk.mask_word = walk.mask_word | ({24'h0, b} << shift);
            else if (walk.code == CODE_ROUTER)
              walk.router_word = walk.router_word | ({24'h0, b} << shift);
            else walk.dns_word = walk.dns_word | ({24'h0, b} << shift);
            if (walk.pos == 2'd3) walk.code = NO_CAPTURE;
            else walk.pos = walk.pos + 2'd1;
          end
        end
        walk.bytes_left = walk.bytes_left - 8'd1;
        if (walk.bytes_left == 8'h00) walk.phase = PH_CODE;
      end
      default: ;
    endcase
    if (!last) return 1'b0;
    res.message_type   = walk.found[FLG_TYPE] ? walk.type_value : 8'h00;
    res.type_found     = walk.found[FLG_TYPE];
    res.subnet_mask    = walk.mask_word;
    res.mask_found     = walk.found[FLG_MASK];
    res.router_address = walk.router_word;
    res.router_found   = walk.found[FLG_ROUTER];
    res.dns_address    = walk.dns_word;
    res.dns_found      = walk.found[FLG_DNS];
    res.end_seen       = walk.finished;
    res.truncated      = !walk.finished && walk.phase != PH_CODE;
    walk = '0;
    return 1'b1;
  endfunction

  // Present one byte, hold it until the transfer, then predict its effect.
  task automatic send_byte(input logic [7:0] b, input logic last, input logic typed,
                           input result_t typed_res);
    result_t res;
    while (!calm && $urandom_range(99) < 6) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    option_byte_i <= b;
    last_byte_i   <= last;
    do @(posedge clk_i); while (!in_ready_o);
    if (walk.phase != PH_DONE) bytes_taken++;
    if (walk_byte(b, last, res)) pending_results.push_back(typed ? typed_res : res);
  endtask

  // Fill msg_bytes with one options area: mostly well formed, some cut short, some noise.
  task automatic build_message();
    int unsigned kind;
    int unsigned pick;
    int unsigned len;
    int unsigned cut;
    logic [7:0]  code;
    msg_bytes.delete();
    kind = $urandom_range(99);
    if (kind < 12) begin
      repeat ($urandom_range(12, 1)) msg_bytes.push_back(8'($urandom_range(255)));
      return;
    end
    repeat ($urandom_range(6)) begin
      pick = $urandom_range(99);
      if (pick < 10) begin
        msg_bytes.push_back(CODE_PAD);
      end else begin
        if (pick < 70) begin
          case ($urandom_range(3))
            0:       code = CODE_TYPE;
            1:       code = CODE_MASK;
            2:       code = CODE_ROUTER;
            default: code = CODE_DNS;
          endcase
        end else begin
          code = 8'($urandom_range(254, 1));
        end
        pick = $urandom_range(99);
        if (pick < 15) len = 0;
        else if (pick < 98) len = $urandom_range(6, 1);
        else len = $urandom_range(255, 7);
        msg_bytes.push_back(code);
        msg_bytes.push_back(8'(len));
        repeat (len) msg_bytes.push_back(8'($urandom_range(255)));
      end
    end
    if ($urandom_range(99) < 85) begin
      msg_bytes.push_back(CODE_END);
      repeat ($urandom_range(3)) msg_bytes.push_back(8'($urandom_range(255)));
    end
    // break the message off somewhere inside
    if (kind < 27 && msg_bytes.size() > 1) begin
      cut = $urandom_range(msg_bytes.size() - 1, 1);
      while (msg_bytes.size() > cut) void'(msg_bytes.pop_back());
    end
    if (msg_bytes.size() == 0) msg_bytes.push_back(CODE_END);
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected 0x%0h, actual 0x%0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin
    out_ready_i <= calm ? 1'b1 : ($urandom_range(99) >= 6);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      seen_res = {message_type_o, type_found_o, subnet_mask_o, mask_found_o, router_address_o,
                  router_found_o, dns_address_o, dns_found_o, end_seen_o, truncated_o};
      if (pending_results.size() == 0) begin
        $display("%0t: result transfer with no result expected, actual 0x%0h", $time, seen_res);
        mismatches++;
      end else begin
        want_res = pending_results.pop_front();
        check_field("message_type", 32'(want_res.message_type), 32'(seen_res.message_type));
        check_field("type_found", 32'(want_res.type_found), 32'(seen_res.type_found));
        check_field("subnet_mask", want_res.subnet_mask, seen_res.subnet_mask);
        check_field("mask_found", 32'(want_res.mask_found), 32'(seen_res.mask_found));
        check_field("router_address", want_res.router_address, seen_res.router_address);
        check_field("router_found", 32'(want_res.router_found), 32'(seen_res.router_found));
        check_field("dns_address", want_res.dns_address, seen_res.dns_address);
        check_field("dns_found", 32'(want_res.dns_found), 32'(seen_res.dns_found));
        check_field("end_seen", 32'(want_res.end_seen), 32'(seen_res.end_seen));
        check_field("truncated", 32'(want_res.truncated), 32'(seen_res.truncated));
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    int unsigned msg_idx;
    walk = '0;
    dir_rows = '{
      // end option alone
      {8'hFF, 1'b1, 1'b1, {8'h00, 1'b0, 32'h0, 1'b0, 32'h0, 1'b0, 32'h0, 1'b0, 1'b1, 1'b0}},
      // single pad
      {8'h00, 1'b1, 1'b1, NO_RESULT},
      // code with no length
      {8'h35, 1'b1, 1'b1, {8'h00, 1'b0, 32'h0, 1'b0, 32'h0, 1'b0, 32'h0, 1'b0, 1'b0, 1'b1}},
      // all-ones mask, last byte closes the entry
      {8'h01, 1'b0, 1'b0, NO_RESULT},
      {8'h04, 1'b0, 1'b0, NO_RESULT},
      {8'hFF, 1'b0, 1'b0, NO_RESULT},
      {8'hFF, 1'b0, 1'b0, NO_RESULT},
      {8'hFF, 1'b0, 1'b0, NO_RESULT},
      {8'hFF, 1'b1, 1'b1, {8'h00, 1'b0, 32'hFFFF_FFFF, 1'b1, 32'h0, 1'b0, 32'h0, 1'b0, 1'b0, 1'b0}},
      // zero-length dns, then short dns, type zero, repeated type, end, ignored byte
      {8'h06, 1'b0, 1'b0, NO_RESULT},
      {8'h00, 1'b0, 1'b0, NO_RESULT},
      {8'h06, 1'b0, 1'b0, NO_RESULT},
      {8'h02, 1'b0, 1'b0, NO_RESULT},
      {8'h80, 1'b0, 1'b0, NO_RESULT},
      {8'h01, 1'b0, 1'b0, NO_RESULT},
      {8'h35, 1'b0, 1'b0, NO_RESULT},
      {8'h01, 1'b0, 1'b0, NO_RESULT},
      {8'h00, 1'b0, 1'b0, NO_RESULT},
      {8'h35, 1'b0, 1'b0, NO_RESULT},
      {8'h01, 1'b0, 1'b0, NO_RESULT},
      {8'h07, 1'b0, 1'b0, NO_RESULT},
      {8'hFF, 1'b0, 1'b0, NO_RESULT},
      {8'h12, 1'b1, 1'b0, NO_RESULT},
      // router value cut short
      {8'h03, 1'b0, 1'b0, NO_RESULT},
      {8'h03, 1'b0, 1'b0, NO_RESULT},
      {8'h7F, 1'b1, 1'b0, NO_RESULT}
    };
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) send_byte(dir_rows[i].b, dir_rows[i].last, dir_rows[i].typed,
                                    dir_rows[i].exp);

    bytes_taken = 0;
    msg_idx = 0;
    while (bytes_taken < RANDOM_BYTES) begin
      calm = (msg_idx >= 25 && msg_idx < 40);
      // hold the input until every result is out
      if (msg_idx == 12) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
        while (pending_results.size() != 0) @(posedge clk_i);
      end
      build_message();
      foreach (msg_bytes[i]) send_byte(msg_bytes[i], i == msg_bytes.size() - 1, 1'b0, NO_RESULT);
      msg_idx++;
    end
    calm = 1'b0;
    in_valid_i <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
